>>> design/ohp_pkg.sv
// Types, codes and constant tables for the object header parser.
// No dependencies; every other file of the block imports this package.
package ohp_pkg;

   typedef struct packed {
      logic [7:0] byte_value;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  payload_byte;
      logic [1:0]  object_type;
      logic [63:0] payload_size;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

   // Results one parsed byte pushes into the output queue (zero, one or two).
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   typedef enum logic [2:0] {
      PH_TYPE,
      PH_LEAD,
      PH_DIGITS,
      PH_JUNK,
      PH_PAYLOAD,
      PH_TAIL
   } phase_type;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_MALFORMED = 2'd1;
   localparam logic [1:0] STATUS_RANGE     = 2'd2;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

   localparam int TYPE_COUNT = 4;

   // Length of each type word: commit, blob, tree, tag.
   function automatic logic [2:0] type_len(input logic [1:0] idx);
      logic [2:0] len;
      unique case (idx)
         2'd0: len = 3'd6;
         2'd1: len = 3'd4;
         2'd2: len = 3'd4;
         2'd3: len = 3'd3;
         default: len = 3'd0;
      endcase
      return len;
   endfunction

   // Character at position pos of type word idx.
   function automatic logic [7:0] type_char(input logic [1:0] idx, input logic [2:0] pos);
      logic [7:0] ch;
      ch = 8'h00;
      unique case (idx)
         2'd0: unique case (pos)
            3'd0: ch = "c";
            3'd1: ch = "o";
            3'd2: ch = "m";
            3'd3: ch = "m";
            3'd4: ch = "i";
            3'd5: ch = "t";
            default: ch = 8'h00;
         endcase
         2'd1: unique case (pos)
            3'd0: ch = "b";
            3'd1: ch = "l";
            3'd2: ch = "o";
            3'd3: ch = "b";
            default: ch = 8'h00;
         endcase
         2'd2: unique case (pos)
            3'd0: ch = "t";
            3'd1: ch = "r";
            3'd2: ch = "e";
            3'd3: ch = "e";
            default: ch = 8'h00;
         endcase
         2'd3: unique case (pos)
            3'd0: ch = "t";
            3'd1: ch = "a";
            3'd2: ch = "g";
            default: ch = 8'h00;
         endcase
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

>>> design/ohp_parser.sv
// Header parse state and per-byte next-state logic of the object header parser.
// Depends on ohp_pkg; emits up to two results per byte as a push_type bundle.
module ohp_parser import ohp_pkg::*; #(
   parameter int SIZE_BITS = 64
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     step,
   input  req_type  item,
   output push_type push
);

   localparam int WIDE_BITS = SIZE_BITS + 4;

   phase_type              phase_ff, phase_in;
   logic [3:0]             cand_ff, cand_in;
   logic [2:0]             name_len_ff, name_len_in;
   logic [SIZE_BITS-1:0]   size_ff, size_in;
   logic                   ovf_ff, ovf_in;
   logic                   neg_ff, neg_in;
   logic                   digits_ff, digits_in;
   logic                   err_ff, err_in;
   logic [SIZE_BITS-1:0]   remain_ff, remain_in;
   logic [1:0]             type_ff, type_in;

   logic [7:0]             b;
   logic                   is_digit;
   logic                   is_ws;
   logic [WIDE_BITS-1:0]   wide;
   logic [WIDE_BITS-1:0]   prod;
   logic                   hit_found;
   logic [1:0]             hit_idx;
   logic                   end_err;
   logic [SIZE_BITS-1:0]   end_size;
   rsp_type                pay_res;
   rsp_type                stat_res;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_TYPE;
         cand_ff     <= 4'hF;
         name_len_ff <= '0;
         size_ff     <= '0;
         ovf_ff      <= 1'b0;
         neg_ff      <= 1'b0;
         digits_ff   <= 1'b0;
         err_ff      <= 1'b0;
         remain_ff   <= '0;
         type_ff     <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         cand_ff     <= cand_in;
         name_len_ff <= name_len_in;
         size_ff     <= size_in;
         ovf_ff      <= ovf_in;
         neg_ff      <= neg_in;
         digits_ff   <= digits_in;
         err_ff      <= err_in;
         remain_ff   <= remain_in;
         type_ff     <= type_in;
      end
   end

   assign b        = item.byte_value;
   assign is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
   assign is_ws    = (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));

   // size * 10 + digit, with four guard bits to catch overflow
   assign wide = WIDE_BITS'(size_ff);
   assign prod = (wide << 3) + (wide << 1) + WIDE_BITS'(b[3:0]);

   // close of header: what the NUL byte would leave behind
   assign end_err  = err_ff | ~digits_ff;
   assign end_size = neg_ff ? (~size_ff + 1'b1) : size_ff;

   always_comb begin
      hit_found = 1'b0;
      hit_idx   = 2'd0;
      for (int i = 0; i < TYPE_COUNT; i++) begin
         if (cand_ff[i] && (name_len_ff == type_len(2'(i)))) begin
            hit_found = 1'b1;
            hit_idx   = 2'(i);
         end
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      cand_in     = cand_ff;
      name_len_in = name_len_ff;
      size_in     = size_ff;
      ovf_in      = ovf_ff;
      neg_in      = neg_ff;
      digits_in   = digits_ff;
      err_in      = err_ff;
      remain_in   = remain_ff;
      type_in     = type_ff;

      pay_res              = '0;
      pay_res.kind         = KIND_PAYLOAD;
      pay_res.payload_byte = b;
      stat_res             = '0;
      stat_res.kind        = KIND_STATUS;
      stat_res.last        = 1'b1;
      push                 = '0;

      unique case (phase_ff)
         PH_TYPE: begin
            if (b == CHAR_SPACE) begin
               if (hit_found) begin
                  type_in  = hit_idx;
                  phase_in = PH_LEAD;
               end else begin
                  err_in   = 1'b1;
                  phase_in = PH_JUNK;
               end
            end else begin
               for (int i = 0; i < TYPE_COUNT; i++) begin
                  if (cand_ff[i] && ((name_len_ff >= type_len(2'(i))) ||
                                     (type_char(2'(i), name_len_ff) != b))) begin
                     cand_in[i] = 1'b0;
                  end
               end
               if (name_len_ff != 3'd7) name_len_in = name_len_ff + 3'd1;
            end
         end
         PH_LEAD, PH_DIGITS, PH_JUNK: begin
            priority if (b == CHAR_NUL) begin
               err_in = end_err;
               if (ovf_ff || end_err) begin
                  phase_in = PH_TAIL;
               end else begin
                  size_in   = end_size;
                  remain_in = end_size;
                  phase_in  = (end_size != '0) ? PH_PAYLOAD : PH_TAIL;
               end
            end else if (phase_ff == PH_JUNK) begin
               // drop everything up to the NUL
            end else if (phase_ff == PH_LEAD && is_ws) begin
               // skip leading whitespace
            end else if (phase_ff == PH_LEAD && (b == CHAR_PLUS || b == CHAR_MINUS)) begin
               neg_in   = (b == CHAR_MINUS);
               phase_in = PH_DIGITS;
            end else if (is_digit) begin
               digits_in = 1'b1;
               phase_in  = PH_DIGITS;
               if (!ovf_ff) begin
                  if (prod[WIDE_BITS-1:SIZE_BITS] != '0) ovf_in = 1'b1;
                  else size_in = prod[SIZE_BITS-1:0];
               end
            end else begin
               err_in   = 1'b1;
               phase_in = PH_JUNK;
            end
         end
         PH_PAYLOAD: begin
            push.count = 2'd1;
            push.first = pay_res;
            remain_in  = remain_ff - 1'b1;
            if (remain_ff == SIZE_BITS'(1)) phase_in = PH_TAIL;
         end
         PH_TAIL: begin
            // ignore bytes past the declared size
         end
         default: begin
            phase_in = PH_TYPE;
         end
      endcase

      if (item.last_byte) begin
         if (phase_in == PH_TAIL) begin
            stat_res.status = ovf_in ? STATUS_RANGE :
                              (err_in ? STATUS_MALFORMED : STATUS_OK);
            if (!ovf_in && !err_in) begin
               stat_res.object_type  = type_in;
               stat_res.payload_size = 64'(size_in);
            end
         end else if (phase_in == PH_PAYLOAD) begin
            stat_res.status       = STATUS_MALFORMED;
            stat_res.payload_size = 64'(size_in);
         end else begin
            stat_res.status = STATUS_MALFORMED;
         end

         if (push.count == 2'd1) begin
            push.second = stat_res;
            push.count  = 2'd2;
         end else begin
            push.first = stat_res;
            push.count = 2'd1;
         end

         // start over for the next object
         phase_in    = PH_TYPE;
         cand_in     = 4'hF;
         name_len_in = '0;
         size_in     = '0;
         ovf_in      = 1'b0;
         neg_in      = 1'b0;
         digits_in   = 1'b0;
         err_in      = 1'b0;
         remain_in   = '0;
         type_in     = '0;
      end

      // push only for a byte that advances the parser
      if (!step) push = '0;
   end

endmodule

>>> design/ohp_out_queue.sv
// Four-entry result queue that takes up to two results a cycle and
// hands one a cycle to the rsp channel when rsp_stall is low. Depends on ohp_pkg.
module ohp_out_queue import ohp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     room,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   localparam int DEPTH = 4;

   rsp_type    mem_ff [DEPTH];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic       pop;

   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_data  = mem_ff[rd_ptr_ff];
   assign pop       = rsp_valid && !rsp_stall;
   // at least two free slots, ignoring any transfer this cycle
   assign room      = (count_ff <= 3'd2);

   assign wr_ptr_in = wr_ptr_ff + push.count;
   assign rd_ptr_in = rd_ptr_ff + 2'(pop);
   assign count_in  = count_ff + 3'(push.count) - 3'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) mem_ff[wr_ptr_ff] <= push.first;
      if (push.count == 2'd2) mem_ff[wr_ptr_ff + 2'd1] <= push.second;
   end

endmodule

>>> design/object_header_parser.sv
// Object header parser: input register, header parser and result queue.
// Depends on ohp_pkg, ohp_parser and ohp_out_queue.
//
// Parses a decompressed object, one byte per transfer, whose header reads
// "type size NUL" (type is commit, blob, tree or tag; size is decimal under
// strtoul rules, wrapping modulo 2^SIZE_BITS when negated). Header bytes give
// no result, each of the first size payload bytes gives one payload result,
// later bytes are dropped, and the byte flagged last_byte gives a final
// status result (after its payload result, if it had one). A byte is taken
// whenever the input register is free or being parsed: it lands in that
// register, is parsed while the queue has room, and its results enter a
// four-entry queue that feeds the rsp channel. The input stalls only while
// that queue holds more than two results; a consumer that takes one result a
// cycle keeps the block at one byte per cycle.
module object_header_parser import ohp_pkg::*; #(
   parameter int SIZE_BITS = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic     in_valid_ff, in_valid_in;
   req_type  in_data_ff;
   logic     room;
   logic     step;
   logic     take;
   push_type push;

   assign step      = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign take      = req_valid && !req_stall;
   assign in_valid_in = take ? 1'b1 : (step ? 1'b0 : in_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) in_data_ff <= req_data;
   end

   ohp_parser #(
      .SIZE_BITS (SIZE_BITS)
   ) u_parser (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .item  (in_data_ff),
      .push  (push)
   );

   ohp_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

>>> design/ohp_checker.sv
// Port-level checks on the result channel of the object header parser.
// Depends on ohp_pkg; bound to object_header_parser at the end of this file.
module ohp_checker import ohp_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // payload transfers carry nothing but the byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_PAYLOAD |->
         !rsp_data.last && rsp_data.status == STATUS_OK &&
         rsp_data.object_type == 2'd0 && rsp_data.payload_size == 64'd0)
      else $error("payload result carries status fields");

   // status transfers close the object and carry no byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_STATUS |->
         rsp_data.last && rsp_data.payload_byte == 8'd0)
      else $error("status result malformed");

   // only defined status codes; type reported only on success
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_STATUS |->
         (rsp_data.status == STATUS_OK || rsp_data.status == STATUS_MALFORMED ||
          rsp_data.status == STATUS_RANGE) &&
         (rsp_data.status == STATUS_OK || rsp_data.object_type == 2'd0))
      else $error("bad status or type on status result");

   // right after reset no result is valid and the input is not stalled
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("activity straight after reset");

endmodule

bind object_header_parser ohp_checker u_ohp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
